### hdl/ppt_pkg.sv
// ============================================================================
// ppt_pkg
// Shared types, codes and helpers of the peak position tracker.
// ============================================================================
package ppt_pkg;

    localparam int unsigned MAX_BINS_DEFAULT = 256;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MAG_W    = 15;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned GAP_W    = 8;
    localparam int unsigned LOST_W   = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [MAG_W-1:0]  THRESHOLD_RESET  = MAG_W'(328);
    localparam logic [GAP_W-1:0]  GAP_RESET        = GAP_W'(3);
    localparam logic [LOST_W-1:0] LOST_LIMIT_RESET = LOST_W'(4);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_GAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_VALID   = 2'd1,
        ST_LOST    = 2'd2
    } status_t;

    // What the bin scan knows about the current frame, including the
    // sample being processed this cycle.
    typedef struct packed {
        logic [POS_W-1:0]    hit_bin;
        logic [SAMPLE_W-1:0] hit_sample;
        logic [SAMPLE_W-1:0] held_sample;
    } frame_sum_t;

    // Saturating absolute value of a Q1.15 sample.
    function automatic logic [MAG_W-1:0] magnitude_of(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] neg;
        neg = (~s) + SAMPLE_W'(1);
        if (!s[SAMPLE_W-1]) begin
            return s[MAG_W-1:0];
        end else if (neg[SAMPLE_W-1]) begin
            return {MAG_W{1'b1}};
        end else begin
            return neg[MAG_W-1:0];
        end
    endfunction

endpackage

### hdl/ppt_frame_scan.sv
// ============================================================================
// ppt_frame_scan
// Walks the bins of one frame and keeps the running peak and held sample.
// ============================================================================
module ppt_frame_scan
    import ppt_pkg::*;
#(
    parameter int unsigned MAX_BINS = MAX_BINS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                last,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [MAG_W-1:0]    threshold,
    input  logic [POS_W-1:0]    prev_position,
    output frame_sum_t          frame_sum
);

    localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);

    logic [CNT_W-1:0]    bin_cnt_reg, bin_cnt_next;
    logic [MAG_W-1:0]    best_mag_reg, best_mag_next;
    logic [POS_W-1:0]    best_bin_reg, best_bin_next;
    logic [SAMPLE_W-1:0] best_sample_reg, best_sample_next;
    logic [SAMPLE_W-1:0] held_sample_reg, held_sample_next;

    logic             in_range;
    logic [POS_W-1:0] bin;
    logic [MAG_W-1:0] mag;

    always_comb begin
        in_range         = bin_cnt_reg < CNT_W'(MAX_BINS);
        bin              = POS_W'(bin_cnt_reg);
        mag              = magnitude_of(sample);
        bin_cnt_next     = bin_cnt_reg;
        best_mag_next    = best_mag_reg;
        best_bin_next    = best_bin_reg;
        best_sample_next = best_sample_reg;
        held_sample_next = held_sample_reg;
        if (in_range) begin
            if (bin == prev_position) begin
                held_sample_next = sample;
            end
            if (bin != '0 && mag >= threshold && mag > best_mag_reg) begin
                best_mag_next    = mag;
                best_bin_next    = bin;
                best_sample_next = sample;
            end
            bin_cnt_next = bin_cnt_reg + CNT_W'(1);
        end
    end

    assign frame_sum.hit_bin     = best_bin_next;
    assign frame_sum.hit_sample  = best_sample_next;
    assign frame_sum.held_sample = held_sample_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_cnt_reg     <= '0;
            best_mag_reg    <= '0;
            best_bin_reg    <= '0;
            best_sample_reg <= '0;
            held_sample_reg <= '0;
        end else if (step) begin
            if (last) begin
                bin_cnt_reg     <= '0;
                best_mag_reg    <= '0;
                best_bin_reg    <= '0;
                best_sample_reg <= '0;
                held_sample_reg <= '0;
            end else begin
                bin_cnt_reg     <= bin_cnt_next;
                best_mag_reg    <= best_mag_next;
                best_bin_reg    <= best_bin_next;
                best_sample_reg <= best_sample_next;
                held_sample_reg <= held_sample_next;
            end
        end
    end

endmodule

### hdl/ppt_track.sv
// ============================================================================
// ppt_track
// Continuity rule across frames and the result register.
// ============================================================================
module ppt_track
    import ppt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                last,
    input  frame_sum_t          frame_sum,
    input  logic [GAP_W-1:0]    track_gap,
    input  logic [LOST_W-1:0]   lost_limit,
    input  logic                res_ready,
    output logic [POS_W-1:0]    prev_position,
    output logic                res_valid,
    output status_t             res_status,
    output logic [POS_W-1:0]    res_position,
    output logic [SAMPLE_W-1:0] res_value
);

    logic [POS_W-1:0]  prev_pos_reg, prev_pos_next;
    logic [LOST_W-1:0] lost_cnt_reg, lost_cnt_next;
    logic              searching_reg, searching_next;

    logic                res_valid_reg;
    status_t             status_reg, status_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SAMPLE_W-1:0] value_reg, value_next;

    logic [POS_W-1:0] bin_dist;
    logic             can_hold;

    always_comb begin
        bin_dist = (frame_sum.hit_bin > prev_pos_reg) ? frame_sum.hit_bin - prev_pos_reg
                                                      : prev_pos_reg - frame_sum.hit_bin;
        can_hold       = lost_cnt_reg < lost_limit;
        prev_pos_next  = prev_pos_reg;
        lost_cnt_next  = lost_cnt_reg;
        searching_next = searching_reg;
        status_next    = ST_INVALID;
        pos_next       = '0;
        value_next     = '0;

        if (frame_sum.hit_bin != '0 && (searching_reg || bin_dist <= track_gap)) begin
            // Accepted hit: first after a restart, or close to the last one.
            status_next    = ST_VALID;
            pos_next       = frame_sum.hit_bin;
            value_next     = frame_sum.hit_sample;
            prev_pos_next  = frame_sum.hit_bin;
            lost_cnt_next  = '0;
            searching_next = 1'b0;
        end else if (!searching_reg) begin
            // Far hit or no hit while tracking.
            if (can_hold) begin
                status_next   = ST_LOST;
                pos_next      = prev_pos_reg;
                value_next    = frame_sum.held_sample;
                lost_cnt_next = lost_cnt_reg + LOST_W'(1);
            end else begin
                pos_next       = frame_sum.hit_bin;
                lost_cnt_next  = '0;
                searching_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pos_reg  <= '0;
            lost_cnt_reg  <= '0;
            searching_reg <= 1'b1;
            res_valid_reg <= 1'b0;
        end else begin
            if (step && last) begin
                prev_pos_reg  <= prev_pos_next;
                lost_cnt_reg  <= lost_cnt_next;
                searching_reg <= searching_next;
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && last) begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            value_reg  <= value_next;
        end
    end

    assign prev_position = prev_pos_reg;
    assign res_valid     = res_valid_reg;
    assign res_status    = status_reg;
    assign res_position  = pos_reg;
    assign res_value     = value_reg;

endmodule

### hdl/peak_position_tracker_unit.sv
// ============================================================================
// peak_position_tracker_unit
// Per-frame peak search over range bins with a continuity tracker.
// ============================================================================
// The block takes one range-bin sample per request and sustains one request
// per clock cycle. A request lands in an input register, from which the bin
// scan and, on the frame's last sample, the continuity rule are evaluated in a
// single pass into the result register that drives m_tvalid. The input
// register and the result register decouple the two sides: samples keep
// flowing while a result waits, and only a frame-ending sample stalls if the
// previous result has not yet been taken. The result status travels on
// m_tuser. Configuration writes are accepted in every cycle and must only be
// issued while the block is idle.
module peak_position_tracker_unit
    import ppt_pkg::*;
#(
    parameter int unsigned MAX_BINS = MAX_BINS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Sample stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] sample
    input  logic                  s_tlast,   // last_in_frame
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [7:0] position, [23:8] breath_value
    output logic [1:0]            m_tuser    // [1:0] status
);

    // Configuration registers.
    logic [MAG_W-1:0]  threshold_reg;
    logic [GAP_W-1:0]  track_gap_reg;
    logic [LOST_W-1:0] lost_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RESET;
            track_gap_reg  <= GAP_RESET;
            lost_limit_reg <= LOST_LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_THRESHOLD:  threshold_reg  <= cfg_data[MAG_W-1:0];
                REG_TRACK_GAP:  track_gap_reg  <= cfg_data[GAP_W-1:0];
                REG_LOST_LIMIT: lost_limit_reg <= cfg_data[LOST_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register. The held sample is processed whenever its result, if
    // any, has somewhere to go.
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                in_last_reg;
    logic                step;
    logic                res_valid;

    assign step     = in_valid_reg && (!in_last_reg || !res_valid || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
            in_last_reg   <= s_tlast;
        end
    end

    // Bin scan within the frame.
    frame_sum_t       frame_sum;
    logic [POS_W-1:0] prev_position;

    ppt_frame_scan #(
        .MAX_BINS(MAX_BINS)
    ) u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .last          (in_last_reg),
        .sample        (in_sample_reg),
        .threshold     (threshold_reg),
        .prev_position (prev_position),
        .frame_sum     (frame_sum)
    );

    // Continuity rule and result register.
    status_t             res_status;
    logic [POS_W-1:0]    res_position;
    logic [SAMPLE_W-1:0] res_value;

    ppt_track u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .last          (in_last_reg),
        .frame_sum     (frame_sum),
        .track_gap     (track_gap_reg),
        .lost_limit    (lost_limit_reg),
        .res_ready     (m_tready),
        .prev_position (prev_position),
        .res_valid     (res_valid),
        .res_status    (res_status),
        .res_position  (res_position),
        .res_value     (res_value)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {res_value, res_position};
    assign m_tuser  = res_status;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the peak position tracker. Frames of range-bin
// samples are streamed in with random gaps and back pressure. A tracker model
// kept in the bench predicts the per-frame report, and every report that the
// block sends is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
    import ppt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BIN_LIMIT    = MAX_BINS_DEFAULT;
    localparam int unsigned STALL_LIMIT  = 2000;  // cycles without any request
    localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off in cycles
    localparam int unsigned DRAIN_CYCLES = 8;     // well past the result latency
    localparam int unsigned PHASE_BINS   = 150;
    localparam int unsigned NUM_PHASES   = 7;
    localparam int unsigned MAX_REPORTS  = 10;

    // Index past the last register; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Fields of one predicted report.
    typedef struct packed {
        logic [SAMPLE_W-1:0] breath_value;
        logic [POS_W-1:0]    position;
        status_t             status;
    } frame_report_t;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } bin_item_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic [1:0]            m_tuser;

    peak_position_tracker_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Tracker model: register copies, per-frame scan state and track state.
    // ------------------------------------------------------------------------
    logic [MAG_W-1:0]    thr_q;
    logic [GAP_W-1:0]    gap_q;
    logic [LOST_W-1:0]   lost_lim_q;
    int unsigned         scan_bin;
    logic [MAG_W-1:0]    best_mag;
    logic [POS_W-1:0]    best_bin;
    logic [SAMPLE_W-1:0] best_smp;
    logic [POS_W-1:0]    track_pos;
    logic [SAMPLE_W-1:0] track_smp;
    logic [LOST_W-1:0]   miss_run;
    bit                  hunting;

    frame_report_t predicted_reports[$];
    bin_item_t     bin_queue[$];
    int unsigned   bins_queued = 0;
    int unsigned   bins_accepted = 0;
    int unsigned   mismatches = 0;

    // Pacing controls set by the stimulus process.
    bit          sender_idle = 1'b0;
    bit          receiver_idle = 1'b0;
    int unsigned hold_requests = 0;
    int          target_bin = 1;
    int          target_cap = 30;

    // Handshakes seen at the last rising edge, for the falling-edge drivers.
    logic s_taken = 1'b0;
    logic m_taken = 1'b0;

    task automatic reset_tracker();
        thr_q      = THRESHOLD_RESET;
        gap_q      = GAP_RESET;
        lost_lim_q = LOST_LIMIT_RESET;
        scan_bin   = 0;
        best_mag   = '0;
        best_bin   = '0;
        best_smp   = '0;
        track_pos  = '0;
        track_smp  = '0;
        miss_run   = '0;
        hunting    = 1'b1;
    endtask

    // Advances the model by one sample. Returns 1 with the frame report when
    // the sample closes a frame.
    function automatic bit track_bin(input logic [SAMPLE_W-1:0] s, input logic last,
                                     output frame_report_t r);
        logic [SAMPLE_W-1:0] neg;
        logic [MAG_W-1:0]    mag;
        int                  bin_dist;
        r.status       = ST_INVALID;
        r.position     = '0;
        r.breath_value = '0;
        // Bins past the largest index are dropped, but the last flag still counts.
        if (scan_bin < BIN_LIMIT) begin
            neg = 16'd0 - s;
            if (!s[SAMPLE_W-1])
                mag = s[MAG_W-1:0];
            else if (neg[SAMPLE_W-1])
                mag = '1;   // the most negative sample saturates
            else
                mag = neg[MAG_W-1:0];
            if (scan_bin == track_pos)
                track_smp = s;
            // Bin zero never counts, and only a strictly larger magnitude wins.
            if (scan_bin != 0 && mag >= thr_q && mag > best_mag) begin
                best_mag = mag;
                best_bin = POS_W'(scan_bin);
                best_smp = s;
            end
            scan_bin++;
        end
        if (!last)
            return 1'b0;

        bin_dist = int'(best_bin) - int'(track_pos);
        if (bin_dist < 0)
            bin_dist = -bin_dist;
        if (best_bin != 0 && (hunting || bin_dist <= int'(gap_q))) begin
            r.status       = ST_VALID;
            r.position     = best_bin;
            r.breath_value = best_smp;
            hunting        = 1'b0;
            track_pos      = best_bin;
            miss_run       = '0;
        end else if (!hunting) begin
            // A far hit or a frame without a hit while a position is held.
            if (miss_run < lost_lim_q) begin
                miss_run++;
                r.status       = ST_LOST;
                r.position     = track_pos;
                r.breath_value = track_smp;
            end else begin
                r.position = best_bin;
                miss_run   = '0;
                hunting    = 1'b1;
            end
        end
        scan_bin  = 0;
        best_mag  = '0;
        best_bin  = '0;
        best_smp  = '0;
        track_smp = '0;
        return 1'b1;
    endfunction

    function automatic int unsigned draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, 7) : 0;
    endfunction

    // ------------------------------------------------------------------------
    // Sample driver: presents queued bins on the falling edge.
    // ------------------------------------------------------------------------
    int unsigned s_gap = 0;

    always @(negedge aclk) begin : sample_driver
        bin_item_t item;
        logic      next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else if (!s_tvalid || s_taken) begin
            next_valid = 1'b0;
            if (s_gap != 0) begin
                s_gap--;
            end else if (bin_queue.size() != 0) begin
                item = bin_queue.pop_front();
                s_tdata <= item.sample;
                s_tlast <= item.last;
                next_valid = 1'b1;
                s_gap = draw_wait(sender_idle);
            end
            s_tvalid <= next_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Report receiver: random stalls after each request, plus the long
    // hold-off whenever the stimulus asks for one.
    // ------------------------------------------------------------------------
    int unsigned ready_wait = 0;
    int unsigned hold_left = 0;
    int unsigned holds_served = 0;

    always @(negedge aclk) begin : report_receiver
        logic next_ready;
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_wait = 0;
            hold_left = 0;
        end else begin
            next_ready = 1'b1;
            if (hold_left != 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
                next_ready = 1'b0;
            end else if (m_taken) begin
                ready_wait = draw_wait(receiver_idle);
                if (ready_wait != 0) begin
                    ready_wait--;
                    next_ready = 1'b0;
                end
            end else if (ready_wait != 0) begin
                ready_wait--;
                next_ready = 1'b0;
            end
            m_tready <= next_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted sample, checks every report, and
    // ends the run when no request moves for too long.
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin : stream_monitor
        frame_report_t fresh;
        frame_report_t want;
        logic [1:0]    got_status;
        logic [7:0]    got_pos;
        logic [15:0]   got_breath;
        if (!aresetn) begin
            s_taken <= 1'b0;
            m_taken <= 1'b0;
            quiet_cycles = 0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            m_taken <= m_tvalid && m_tready;
            if (s_tvalid && s_tready) begin
                bins_accepted++;
                if (track_bin(s_tdata, s_tlast, fresh))
                    predicted_reports.push_back(fresh);
            end
            if (m_tvalid && m_tready) begin
                got_status = m_tuser;
                got_pos    = m_tdata[7:0];
                got_breath = m_tdata[23:8];
                if (predicted_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected report: status %0d pos %0d breath %0d",
                                 $realtime, got_status, got_pos, $signed(got_breath));
                end else begin
                    want = predicted_reports.pop_front();
                    if (got_status !== want.status || got_pos !== want.position ||
                        got_breath !== want.breath_value) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("%0t: report mismatch (expected/actual): status %0d/%0d ",
                                   $realtime, want.status, got_status);
                            $display("position %0d/%0d breath %0d/%0d",
                                     want.position, got_pos,
                                     $signed(want.breath_value), $signed(got_breath));
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_THRESHOLD:  thr_q = value;
            REG_TRACK_GAP:  gap_q = value[GAP_W-1:0];
            REG_LOST_LIMIT: lost_lim_q = value[LOST_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Upper data bits of the narrow registers carry junk on purpose.
    task automatic set_tracking_config(input int unsigned thr, input int unsigned gap,
                                       input int unsigned lost);
        write_register(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_register(REG_TRACK_GAP, {7'($urandom), 8'(gap)});
        write_register(REG_LOST_LIMIT, {7'($urandom), 8'(lost)});
    endtask

    // Returns once every sample is in and every report is out, then lets the
    // pipeline settle before a register may be touched.
    task automatic wait_idle();
        while (bins_accepted != bins_queued || predicted_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_bin(input logic [SAMPLE_W-1:0] s, input logic last);
        bin_item_t item;
        item.sample = s;
        item.last   = last;
        bin_queue.push_back(item);
        bins_queued++;
    endtask

    function automatic logic [SAMPLE_W-1:0] sample_with_magnitude(input int unsigned lo,
                                                                   input int unsigned hi);
        int unsigned m;
        m = $urandom_range(hi, lo);
        if ($urandom_range(0, 1) == 0)
            return SAMPLE_W'(m);
        if (m == 32767 && $urandom_range(0, 1) == 1)
            return 16'h8000;
        return SAMPLE_W'(0 - m);
    endfunction

    // A sample strong enough to count under the current threshold.
    function automatic logic [SAMPLE_W-1:0] peak_sample();
        return sample_with_magnitude((thr_q == 0) ? 1 : thr_q, 32767);
    endfunction

    // One frame of len bins: noise below the threshold (or anything when wild or past the bin range),
    // the peak sample at peak_bin and a copy of it at twin_bin.
    task automatic queue_frame(input int unsigned len, input int unsigned peak_bin,
                               input logic [SAMPLE_W-1:0] peak_s, input int unsigned twin_bin,
                               input bit wild);
        logic [SAMPLE_W-1:0] s;
        int unsigned         noise_hi;
        noise_hi = (thr_q == 0) ? 0 : thr_q - 1;
        for (int unsigned b = 0; b < len; b++) begin
            if (wild || b >= BIN_LIMIT)
                s = SAMPLE_W'($urandom);
            else
                s = sample_with_magnitude(0, noise_hi);
            if (b == peak_bin || b == twin_bin)
                s = peak_s;
            queue_bin(s, b == len - 1);
        end
    endtask

    // Mostly a target that drifts within the tracking gap; now and then a jump,
    // a missing peak, a frame cut short or a frame of random noise around the peak.
    task automatic queue_tracking_frame();
        int unsigned pick;
        int unsigned len;
        int unsigned twin;
        int          step;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            step = (gap_q > 4) ? 4 : int'(gap_q);
            target_bin = target_bin + $urandom_range(0, 2 * step) - step;
        end else if (pick == 6) begin
            target_bin = $urandom_range(1, target_cap);
        end
        if (target_bin < 1)
            target_bin = 1;
        if (target_bin > target_cap)
            target_bin = target_cap;
        len = (pick == 8) ? $urandom_range(1, target_bin) : target_bin + $urandom_range(1, 6);
        twin = (pick != 7 && $urandom_range(0, 3) == 0) ? $urandom_range(1, target_bin + 6) : 0;
        queue_frame(len, (pick == 7) ? 0 : target_bin, peak_sample(), twin, pick == 9);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned first;
        reset_tracker();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register reset values. A lone bin zero at full scale must not hit.
        queue_bin(16'h8000, 1'b1);
        // First hit is taken; the tie on magnitude keeps the earlier bin.
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h8000, 1'b0);
        queue_bin(16'h7fff, 1'b0);
        queue_bin(16'h0148, 1'b1);
        // Strongest hit at the held bin again: the position stays valid.
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h1234, 1'b0);
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h0148, 1'b1);
        // Hit within the gap, exactly at the threshold with a negative sample.
        queue_bin(16'h7fff, 1'b0);
        queue_bin(16'h0010, 1'b0);
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'hfeb8, 1'b1);
        // No hit, and the frame ends before the held bin comes by.
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h0000, 1'b1);
        wait_idle();

        // With no lost frames allowed, a far hit and a missing hit both
        // restart the search at once.
        set_tracking_config(THRESHOLD_RESET, 0, 0);
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h4000, 1'b1);
        queue_bin(16'h0000, 1'b0);
        queue_bin(16'h0200, 1'b1);
        queue_bin(16'h0000, 1'b1);
        wait_idle();

        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: set_tracking_config(0, 0, 0);
                1: set_tracking_config(32767, 255, 255);
                2: set_tracking_config($urandom_range(100, 4000), $urandom_range(1, 6),
                                       $urandom_range(0, 6));
                3: begin
                    write_register(REG_UNUSED, CFG_DATA_W'($urandom));
                    set_tracking_config(THRESHOLD_RESET, GAP_RESET, LOST_LIMIT_RESET);
                end
                4: set_tracking_config($urandom_range(0, 32767), $urandom_range(0, 255),
                                       $urandom_range(0, 255));
                5: set_tracking_config($urandom_range(1, 600), 2, 1);
                default: set_tracking_config($urandom_range(0, 20000), $urandom_range(0, 10),
                                             $urandom_range(0, 10));
            endcase
            sender_idle   = (p % 3 != 0) && p != NUM_PHASES - 1;
            receiver_idle = (p % 3 != 1) && p != NUM_PHASES - 1;
            // Tiny frames in the back-pressure phase so reports pile up fast.
            target_cap    = (p == 5) ? 3 : 30;
            first = bins_queued;
            while (bins_queued - first < PHASE_BINS)
                queue_tracking_frame();
            // A frame longer than the bin range, peak at any nonzero bin in range.
            if (p == 1 || p == 4)
                queue_frame($urandom_range(BIN_LIMIT + 1, BIN_LIMIT + 19),
                            $urandom_range(1, BIN_LIMIT - 1), peak_sample(), 0, 1'b0);
            if (p == 5)
                hold_requests++;
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/ppt_pkg.sv
hdl/ppt_frame_scan.sv
hdl/ppt_track.sv
hdl/peak_position_tracker_unit.sv
tb/tb_top.sv
